/* design/pdf_pkg.sv */
package pdf_pkg;

   // Default fraction width of the Reynolds input and of the result
   localparam int PDF_FRAC_BITS = 16;

   // Squaring steps of the log2 fraction and terms of the 2^f series
   localparam int LOG_STEPS  = 30;
   localparam int TERM_COUNT = 13;

   // Q30 coefficients
   localparam logic [31:0]        K_MID_COEF  = 32'd2541546897;
   localparam logic [31:0]        K_HIGH_COEF = 32'd3739842773;
   localparam logic signed [35:0] K_EXP_BASE  = 36'sd880468296;
   localparam logic signed [35:0] K_EXP_SLOPE = 36'sd16161425;
   localparam logic signed [35:0] K_HIGH_EXP  = 36'sd676994220;
   localparam logic [29:0]        K_LN2       = 30'd744261118;
   localparam logic [30:0]        Q30_ONE     = 31'd1 << 30;
   localparam logic [54:0]        Q30_EIGHTEEN = 55'd18 << 30;
   localparam logic [27:0]        OUT_MAX     = 28'hFFFFFFF;

   typedef enum logic [1:0] {
      REGION_LOW,
      REGION_MID,
      REGION_HIGH
   } region_type;

   // Side data that travels with each item through the arithmetic units
   typedef struct packed {
      region_type  region;
      logic [4:0]  msb;
      logic [16:0] vf;
   } tag_type;

   // Signed Q30 product, truncated toward zero
   function automatic logic signed [35:0] smul_q30(logic signed [35:0] a,
                                                   logic signed [35:0] b);
      logic [35:0] ma;
      logic [35:0] mb;
      logic [71:0] p;
      logic [35:0] q;
      ma = a[35] ? 36'(-a) : 36'(a);
      mb = b[35] ? 36'(-b) : 36'(b);
      p  = ma * mb;
      q  = p[65:30];
      return (a[35] != b[35]) ? -$signed(q) : $signed(q);
   endfunction

endpackage

/* design/pdf_log2.sv */
// Fraction of log2 by repeated squaring, one result bit per stage
module pdf_log2 import pdf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] in_m,
   input  tag_type     in_tag,
   output logic        out_valid,
   output logic [29:0] out_frac,
   output tag_type     out_tag
);

   logic        valid_ff [LOG_STEPS];
   logic [30:0] m_ff     [LOG_STEPS];
   logic [29:0] frac_ff  [LOG_STEPS];
   tag_type     tag_ff   [LOG_STEPS];

   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_step
      logic        v_src;
      logic [30:0] m_src;
      logic [29:0] f_src;
      tag_type     t_src;
      logic [61:0] sq;
      logic [31:0] s;
      logic [30:0] m_in;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign m_src = in_m;
         assign f_src = '0;
         assign t_src = in_tag;
      end else begin : g_next
         assign v_src = valid_ff[k-1];
         assign m_src = m_ff[k-1];
         assign f_src = frac_ff[k-1];
         assign t_src = tag_ff[k-1];
      end

      // Square, renormalize when the value reaches two
      assign sq   = m_src * m_src;
      assign s    = sq[61:30];
      assign m_in = s[31] ? s[31:1] : s[30:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         m_ff[k]    <= m_in;
         frac_ff[k] <= {f_src[28:0], s[31]};
         tag_ff[k]  <= t_src;
      end
   end

   assign out_valid = valid_ff[LOG_STEPS-1];
   assign out_frac  = frac_ff[LOG_STEPS-1];
   assign out_tag   = tag_ff[LOG_STEPS-1];

endmodule

/* design/pdf_exp2.sv */
// 2^e for signed Q30 e: Taylor series of exp(f*ln2), three stages per term
module pdf_exp2 import pdf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [35:0] in_e,
   input  tag_type            in_tag,
   output logic               out_valid,
   output logic [51:0]        out_pow,
   output tag_type            out_tag
);

   typedef struct packed {
      tag_type            tag;
      logic [29:0]        y;
      logic signed [5:0]  ip;
      logic [31:0]        sum;
   } carry_type;

   // Split the exponent
   logic               split_valid_ff;
   logic signed [5:0]  split_ip_ff;
   logic [29:0]        split_f_ff;
   tag_type            split_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
      end else begin
         split_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      split_ip_ff  <= in_e[35:30];
      split_f_ff   <= in_e[29:0];
      split_tag_ff <= in_tag;
   end

   // Series state between terms
   logic        vc_ff [TERM_COUNT+1];
   carry_type   c_ff  [TERM_COUNT+1];
   logic [30:0] t_ff  [TERM_COUNT+1];

   logic [59:0] y_prod;
   assign y_prod = split_f_ff * K_LN2;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff[0] <= 1'b0;
      end else begin
         vc_ff[0] <= split_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_ff[0].tag <= split_tag_ff;
      c_ff[0].y   <= y_prod[59:30];
      c_ff[0].ip  <= split_ip_ff;
      c_ff[0].sum <= 32'(Q30_ONE);
      t_ff[0]     <= Q30_ONE;
   end

   for (genvar k = 0; k < TERM_COUNT; k++) begin : g_term
      localparam int N = k + 1;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);

      logic        va_ff;
      logic        vb_ff;
      carry_type   ca_ff;
      carry_type   cb_ff;
      logic [29:0] p_ff;
      logic [29:0] pb_ff;
      logic [29:0] q_ff;
      logic [60:0] tp;
      logic [62:0] qp;
      logic [33:0] qn;
      logic [33:0] rem;
      logic [30:0] t_in;

      // Multiply the previous term by y
      assign tp = t_ff[k] * c_ff[k].y;
      // Divide by the term index through the reciprocal, then correct once
      assign qp   = p_ff * RECIP;
      assign qn   = q_ff * 34'(N);
      assign rem  = {4'b0, pb_ff} - qn;
      assign t_in = 31'(q_ff) + 31'(rem >= 34'(N));

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff        <= 1'b0;
            vb_ff        <= 1'b0;
            vc_ff[k+1]   <= 1'b0;
         end else begin
            va_ff        <= vc_ff[k];
            vb_ff        <= va_ff;
            vc_ff[k+1]   <= vb_ff;
         end
      end

      always_ff @(posedge clock) begin
         ca_ff <= c_ff[k];
         p_ff  <= tp[59:30];
         cb_ff <= ca_ff;
         pb_ff <= p_ff;
         q_ff  <= qp[61:32];
         c_ff[k+1].tag <= cb_ff.tag;
         c_ff[k+1].y   <= cb_ff.y;
         c_ff[k+1].ip  <= cb_ff.ip;
         c_ff[k+1].sum <= cb_ff.sum + 32'(t_in);
         t_ff[k+1]     <= t_in;
      end
   end

   // Scale the series by the integer part of the exponent
   logic        pow_valid_ff;
   logic [51:0] pow_ff;
   tag_type     pow_tag_ff;
   logic [51:0] pow_in;
   logic [6:0]  neg_ip;
   carry_type   fin;

   assign fin    = c_ff[TERM_COUNT];
   assign neg_ip = 7'(-$signed({fin.ip[5], fin.ip}));

   always_comb begin
      if (!fin.ip[5]) begin
         if (fin.ip > 6'sd20) begin
            pow_in = {fin.sum, 20'b0};
         end else begin
            pow_in = 52'(fin.sum) << fin.ip[4:0];
         end
      end else begin
         pow_in = 52'(fin.sum >> neg_ip);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_valid_ff <= 1'b0;
      end else begin
         pow_valid_ff <= vc_ff[TERM_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      pow_ff     <= pow_in;
      pow_tag_ff <= fin.tag;
   end

   assign out_valid = pow_valid_ff;
   assign out_pow   = pow_ff;
   assign out_tag   = pow_tag_ff;

endmodule

/* design/particle_drag_factor.sv */
// Standard drag curve scaled by liquid volume fraction, fully pipelined.
// Throughput: one item per cycle; busy stays low, as every stage advances each cycle.
// Most of the pipeline lies in the
// 30 squaring stages of the log2 unit and the 39 series stages of the 2^x unit.
// Reset (synchronous, active high) clears the valid bits only; nothing else is kept.
// The receiver cannot stall: each result shows for exactly one cycle.
module particle_drag_factor import pdf_pkg::*; #(
   parameter int FRAC_BITS = PDF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_reynolds,
   input  logic [16:0] req_volume_fraction,
   output logic        rsp_valid,
   output logic [27:0] rsp_drag_value
);

   localparam logic [32:0] LOW_BOUND = 33'(((64'd1 << FRAC_BITS) + 64'd99) / 64'd100);
   localparam logic [32:0] MID_BOUND = 33'(64'd20 << FRAC_BITS);
   localparam int          SHIFT     = 40 - FRAC_BITS;

   assign busy = 1'b0;

   // Capture the transfer
   logic        cap_valid_ff;
   logic [31:0] cap_re_ff;
   logic [16:0] cap_vf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      cap_re_ff <= req_reynolds;
      cap_vf_ff <= req_volume_fraction;
   end

   // Classify, find the leading one, normalize the mantissa
   logic        norm_valid_ff;
   logic [30:0] norm_m_ff;
   tag_type     norm_tag_ff;
   logic [4:0]  msb_in;
   logic [30:0] m_in;
   region_type  region_in;

   always_comb begin
      msb_in = '0;
      for (int i = 1; i < 32; i++) begin
         if (cap_re_ff[i]) begin
            msb_in = 5'(i);
         end
      end
   end

   always_comb begin
      if (msb_in == 5'd31) begin
         m_in = cap_re_ff[31:1];
      end else begin
         m_in = 31'(cap_re_ff << (5'd30 - msb_in));
      end
   end

   always_comb begin
      if ({1'b0, cap_re_ff} < LOW_BOUND) begin
         region_in = REGION_LOW;
      end else if ({1'b0, cap_re_ff} < MID_BOUND) begin
         region_in = REGION_MID;
      end else begin
         region_in = REGION_HIGH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_valid_ff <= 1'b0;
      end else begin
         norm_valid_ff <= cap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      norm_m_ff          <= m_in;
      norm_tag_ff.region <= region_in;
      norm_tag_ff.msb    <= msb_in;
      norm_tag_ff.vf     <= cap_vf_ff;
   end

   // Log2 fraction
   logic        log_valid;
   logic [29:0] log_frac;
   tag_type     log_tag;

   pdf_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid_ff),
      .in_m      (norm_m_ff),
      .in_tag    (norm_tag_ff),
      .out_valid (log_valid),
      .out_frac  (log_frac),
      .out_tag   (log_tag)
   );

   // Assemble log2 Re in signed Q30
   logic               l_valid_ff;
   logic signed [35:0] l_ff;
   tag_type            l_tag_ff;
   logic signed [35:0] l_int;
   logic signed [35:0] l_in;

   assign l_int = $signed({31'b0, log_tag.msb}) - $signed(36'(FRAC_BITS));
   assign l_in  = (l_int <<< 30) + $signed({6'b0, log_frac});

   // Slope term of the middle exponent
   logic               s_valid_ff;
   logic signed [35:0] s_l_ff;
   logic signed [35:0] s_p_ff;
   tag_type            s_tag_ff;

   // Middle exponent
   logic               a_valid_ff;
   logic signed [35:0] a_l_ff;
   logic signed [35:0] a_ff;
   tag_type            a_tag_ff;

   // Exponent of the power
   logic               e_valid_ff;
   logic signed [35:0] e_ff;
   tag_type            e_tag_ff;
   logic signed [35:0] e_op;

   assign e_op = (a_tag_ff.region == REGION_MID) ? a_ff : K_HIGH_EXP;

   always_ff @(posedge clock) begin
      if (reset) begin
         l_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         l_valid_ff <= log_valid;
         s_valid_ff <= l_valid_ff;
         a_valid_ff <= s_valid_ff;
         e_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      l_ff     <= l_in;
      l_tag_ff <= log_tag;
      s_l_ff   <= l_ff;
      s_p_ff   <= smul_q30(K_EXP_SLOPE, l_ff);
      s_tag_ff <= l_tag_ff;
      a_l_ff   <= s_l_ff;
      a_ff     <= K_EXP_BASE - s_p_ff;
      a_tag_ff <= s_tag_ff;
      e_ff     <= smul_q30(e_op, a_l_ff);
      e_tag_ff <= a_tag_ff;
   end

   // Power of two
   logic        pow_valid;
   logic [51:0] pow;
   tag_type     pow_tag;

   pdf_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_e      (e_ff),
      .in_tag    (e_tag_ff),
      .out_valid (pow_valid),
      .out_pow   (pow),
      .out_tag   (pow_tag)
   );

   // Coefficient products, high and low halves of the power
   logic        cm_valid_ff;
   logic [53:0] cm_hi_ff;
   logic [61:0] cm_lo_ff;
   tag_type     cm_tag_ff;
   logic [31:0] coef;

   assign coef = (pow_tag.region == REGION_MID) ? K_MID_COEF : K_HIGH_COEF;

   // Drag factor in Q30
   logic        dr_valid_ff;
   logic [54:0] dr_ff;
   logic [16:0] dr_vf_ff;
   logic [54:0] dr_in;

   always_comb begin
      if (cm_tag_ff.region == REGION_LOW) begin
         dr_in = Q30_EIGHTEEN;
      end else begin
         dr_in = Q30_EIGHTEEN + 55'(cm_hi_ff) + 55'(cm_lo_ff[61:30]);
      end
   end

   // Volume fraction products, split in two halves
   logic        vp_valid_ff;
   logic [41:0] vp_hi_ff;
   logic [40:0] vp_lo_ff;
   logic [48:0] dq;

   assign dq = dr_ff[54:6];

   // Recombine, shift to the output format, saturate
   logic [65:0] prod;
   logic [65:0] scaled;
   logic [27:0] res_in;

   assign prod   = {vp_hi_ff, 24'b0} + 66'(vp_lo_ff);
   assign scaled = prod >> SHIFT;
   assign res_in = (scaled > 66'(OUT_MAX)) ? OUT_MAX : scaled[27:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_valid_ff <= 1'b0;
         dr_valid_ff <= 1'b0;
         vp_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         cm_valid_ff <= pow_valid;
         dr_valid_ff <= cm_valid_ff;
         vp_valid_ff <= dr_valid_ff;
         rsp_valid   <= vp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cm_hi_ff       <= coef * pow[51:30];
      cm_lo_ff       <= coef * pow[29:0];
      cm_tag_ff      <= pow_tag;
      dr_ff          <= dr_in;
      dr_vf_ff       <= cm_tag_ff.vf;
      vp_hi_ff       <= dq[48:24] * dr_vf_ff;
      vp_lo_ff       <= dq[23:0] * dr_vf_ff;
      rsp_drag_value <= res_in;
   end

endmodule
